[src/spp_pkg.sv]
package spp_pkg;

    localparam int LINE_DEPTH = 65536;
    localparam int PTR_W      = $clog2(LINE_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 16;
    localparam int FB_W       = 16;
    localparam int WET_W      = 17;
    // wide enough for the delay register, the pointer and the depth itself
    localparam int CMP_W      = ((PTR_W > DELAY_W) ? PTR_W : DELAY_W) + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WET_W;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET      = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd18000;
    localparam logic [FB_W-1:0]    FB_RESET    = 16'd19661;
    localparam logic [WET_W-1:0]   WET_RESET   = 17'd32768;
    localparam logic [WET_W-1:0]   WET_UNITY   = 17'd65536;

    typedef logic [PTR_W-1:0]           t_ptr;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // pipeline control shared by the datapath and the delay memory
    typedef struct packed {
        logic adv;  // every stage moves on
        logic acc;  // an input transfer enters the pipeline
        logic wr;   // the item in the last stage writes the lines
    } t_pipe_ctl;

    typedef struct packed {
        logic [WET_W-1:0] wet;  // clamped to unity
        logic [WET_W-1:0] dry;
        logic [FB_W-1:0]  fb;
    } t_gains;

    function automatic t_sample sat16(input logic signed [18:0] v);
        t_sample res;
        if (v > 19'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            res = -16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

[src/spp_delay_mem.sv]
module spp_delay_mem
    import spp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_ptr      i_delay,
    input  t_sample   i_wr_left,
    input  t_sample   i_wr_right,
    output t_sample   o_tap_left,
    output t_sample   o_tap_right
);

    t_sample mem_l [LINE_DEPTH];
    t_sample mem_r [LINE_DEPTH];

    t_ptr    r_wp, n_wp;
    logic    r_wrapped;
    t_ptr    r_wp1, r_wp2;
    logic    r_ok1;
    t_sample r_rd_l, r_rd_r;

    t_ptr ridx;
    logic rd_ok;

    always_comb begin
        if (r_wp >= i_delay) begin
            ridx = r_wp - i_delay;
        end else begin
            ridx = PTR_W'(CMP_W'(r_wp) + CMP_W'(LINE_DEPTH) - CMP_W'(i_delay));
        end
        // entries never written since reset read as zero
        rd_ok = r_wrapped || (ridx < r_wp);
        n_wp  = (r_wp == PTR_W'(LINE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (i_ctl.acc) begin
            r_wp <= n_wp;
            if (r_wp == PTR_W'(LINE_DEPTH - 1)) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_wp1 <= r_wp;
            r_wp2 <= r_wp1;
            r_ok1 <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem_l[r_wp2] <= i_wr_left;
        end
        if (i_ctl.adv) begin
            r_rd_l <= mem_l[ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem_r[r_wp2] <= i_wr_right;
        end
        if (i_ctl.adv) begin
            r_rd_r <= mem_r[ridx];
        end
    end

    assign o_tap_left  = r_ok1 ? r_rd_l : '0;
    assign o_tap_right = r_ok1 ? r_rd_r : '0;

endmodule

[src/spp_mix.sv]
module spp_mix
    import spp_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_gains    i_gains,
    input  t_sample   i_left,
    input  t_sample   i_right,
    input  t_sample   i_tap_left,
    input  t_sample   i_tap_right,
    output t_sample   o_wr_left,
    output t_sample   o_wr_right,
    output t_sample   o_out_left,
    output t_sample   o_out_right,
    output t_sample   o_out_mono
);

    // stage 1: input samples, taps arrive from the memory read register
    t_sample r1_xl, r1_xr;

    // stage 2: registered products
    t_sample            r2_xl, r2_xr;
    logic signed [33:0] r2_ld, r2_lw, r2_rd, r2_rw;
    logic signed [32:0] r2_fb_l, r2_fb_r;

    t_sample r_out_l, r_out_r, r_out_m;

    logic signed [17:0] dry_s, wet_s;
    logic signed [16:0] fb_s;

    logic signed [34:0] sum_l, sum_r;
    logic signed [34:0] rnd_l, rnd_r;
    logic signed [32:0] fbr_l, fbr_r;
    logic signed [18:0] line_l, line_r;
    t_sample            mix_l, mix_r;
    logic signed [16:0] msum;

    assign dry_s = signed'({1'b0, i_gains.dry});
    assign wet_s = signed'({1'b0, i_gains.wet});
    assign fb_s  = signed'({1'b0, i_gains.fb});

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r1_xl   <= i_left;
            r1_xr   <= i_right;
            r2_xl   <= r1_xl;
            r2_xr   <= r1_xr;
            r2_ld   <= 34'(r1_xl) * 34'(dry_s);
            r2_lw   <= 34'(i_tap_left) * 34'(wet_s);
            r2_rd   <= 34'(r1_xr) * 34'(dry_s);
            r2_rw   <= 34'(i_tap_right) * 34'(wet_s);
            // ping-pong: each line is fed by the other channel's tap
            r2_fb_l <= 33'(i_tap_right) * 33'(fb_s);
            r2_fb_r <= 33'(i_tap_left) * 33'(fb_s);
        end
    end

    always_comb begin
        sum_l  = 35'(r2_ld) + 35'(r2_lw);
        sum_r  = 35'(r2_rd) + 35'(r2_rw);
        rnd_l  = (sum_l + 35'sd32768) >>> 16;
        rnd_r  = (sum_r + 35'sd32768) >>> 16;
        mix_l  = sat16(rnd_l[18:0]);
        mix_r  = sat16(rnd_r[18:0]);
        fbr_l  = (r2_fb_l + 33'sd32768) >>> 16;
        fbr_r  = (r2_fb_r + 33'sd32768) >>> 16;
        line_l = 19'(r2_xl) + 19'(fbr_l);
        line_r = 19'(r2_xr) + 19'(fbr_r);
        msum   = 17'(mix_l) + 17'(mix_r);
    end

    assign o_wr_left  = sat16(line_l);
    assign o_wr_right = sat16(line_r);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_out_l <= mix_l;
            r_out_r <= mix_r;
            r_out_m <= msum[16:1];
        end
    end

    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_out_mono  = r_out_m;

endmodule

[src/stereo_ping_pong_delay_core.sv]
// channel   dir  handshake                  payload
// s         in   i_s_tvalid / o_s_tready    i_s_tdata: left_in, right_in
// m         out  o_m_tvalid / i_m_tready    o_m_tdata: out_left, out_right, out_mono
// cfg       in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One frame per cycle unless the output stalls or a short delay waits; o_m_tvalid = r_vo.
// Stages: delay-line read, gain multiplies, mix/saturate with line write.
// With a delay of 1 or 2 samples the tap is a frame still in flight, so a
// transfer waits until the pipeline has drained, and frames no longer overlap.
// Synchronous active-low reset; delay lines read as zero until written.
// A stall on the output freezes the whole pipeline, input included.
module stereo_ping_pong_delay_core
    import spp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,   // [15:0] left_in, [31:16] right_in
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [47:0]           o_m_tdata,   // [15:0] out_left, [31:16] out_right,
                                               // [47:32] out_mono
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DELAY_W-1:0] r_delay;
    logic [FB_W-1:0]    r_fb;
    logic [WET_W-1:0]   r_wet;

    logic r_v1, r_v2, r_vo;

    t_pipe_ctl ctl;
    t_gains    gains;
    t_ptr      delay_c;
    logic      hazard;
    logic      in_fire;

    t_sample tap_l, tap_r, wr_l, wr_r, out_l, out_r, out_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
            r_fb    <= FB_RESET;
            r_wet   <= WET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DELAY:    r_delay <= i_cfg_data[DELAY_W-1:0];
                REG_FEEDBACK: r_fb    <= i_cfg_data[FB_W-1:0];
                REG_WET:      r_wet   <= i_cfg_data[WET_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        if (CMP_W'(r_delay) > CMP_W'(LINE_DEPTH - 1)) begin
            delay_c = PTR_W'(LINE_DEPTH - 1);
        end else begin
            delay_c = PTR_W'(r_delay);
        end
        gains.wet = (r_wet > WET_UNITY) ? WET_UNITY : r_wet;
        gains.dry = WET_UNITY - gains.wet;
        gains.fb  = r_fb;
        // tap lands on a frame not yet written back
        hazard    = (delay_c == PTR_W'(1)) || (delay_c == PTR_W'(2));
    end

    assign ctl.adv    = !r_vo || i_m_tready;
    assign o_s_tready = ctl.adv && !(hazard && (r_v1 || r_v2));
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign ctl.acc    = in_fire;
    assign ctl.wr     = r_v2 && ctl.adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else if (ctl.adv) begin
            r_v1 <= in_fire;
            r_v2 <= r_v1;
            r_vo <= r_v2;
        end
    end

    spp_delay_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_delay     (delay_c),
        .i_wr_left   (wr_l),
        .i_wr_right  (wr_r),
        .o_tap_left  (tap_l),
        .o_tap_right (tap_r)
    );

    spp_mix u_mix (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_gains     (gains),
        .i_left      (i_s_tdata[15:0]),
        .i_right     (i_s_tdata[31:16]),
        .i_tap_left  (tap_l),
        .i_tap_right (tap_r),
        .o_wr_left   (wr_l),
        .o_wr_right  (wr_r),
        .o_out_left  (out_l),
        .o_out_right (out_r),
        .o_out_mono  (out_m)
    );

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {out_m, out_r, out_l};

`ifndef SYNTHESIS
    a_hazard_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && hazard |-> !r_v1 && !r_v2)
        else $error("transfer accepted while a short-delay tap was in flight");

    a_fire_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_v1)
        else $error("accepted frame did not enter the pipeline");

    a_last_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.wr |=> r_vo)
        else $error("written frame was not presented on the output");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !i_m_tready |=> $stable(r_v1) && $stable(r_v2))
        else $error("pipeline moved during an output stall");
`endif

endmodule
